### hdl/rsst_pkg.sv
package rsst_pkg;

	// fixed field widths
	localparam int CMD_W = 2;
	localparam int IDX_W = 13;
	localparam int AMT_W = 16;
	localparam int TOT_W = 32;
	localparam int STS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd1;
	localparam logic [STS_W-1:0] STS_RANGE    = 2'd2;

	// leaf count after reset
	localparam logic [IDX_W-1:0] LEAVES_RESET = 13'd4096;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_start;
		logic clr_step;
		logic add_step;
		logic qry_step;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic add_go;
		logic is_query;
		logic is_clear;
		logic add_done;
		logic qry_done;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

### hdl/rsst_datapath.sv
module rsst_datapath #(
	parameter int MAX_LEAVES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsst_pkg::ctl_t              ctl,
	output rsst_pkg::sts_t              sts,
	input  logic                        cfg_we,
	input  logic [rsst_pkg::IDX_W-1:0]  cfg_wdata,
	input  logic [rsst_pkg::CMD_W-1:0]  cmd,
	input  logic [rsst_pkg::IDX_W-1:0]  leaf_index,
	input  logic [rsst_pkg::AMT_W-1:0]  add_amount,
	input  logic [rsst_pkg::IDX_W-1:0]  query_low,
	input  logic [rsst_pkg::IDX_W-1:0]  query_high,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rsst_pkg::TOT_W-1:0]  range_total,
	output logic [rsst_pkg::STS_W-1:0]  status
);

	localparam int SLOTS  = 2 * MAX_LEAVES;
	localparam int ADDR_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam int NODE_W = $clog2(SLOTS + 1);
	localparam int N_W    = ($clog2(MAX_LEAVES + 1) > rsst_pkg::IDX_W) ?
		$clog2(MAX_LEAVES + 1) : rsst_pkg::IDX_W;

	logic [rsst_pkg::TOT_W-1:0] mem_q [0:SLOTS-1];
	logic [rsst_pkg::TOT_W-1:0] rd_data_q;

	logic [rsst_pkg::IDX_W-1:0] cfg_q;
	logic [rsst_pkg::TOT_W-1:0] gt_q;
	logic [rsst_pkg::CMD_W-1:0] cmd_q;
	logic [rsst_pkg::AMT_W-1:0] amt_q;
	logic [rsst_pkg::STS_W-1:0] sts_q;
	logic [ADDR_W-1:0]          ptr_q;
	logic                       wb_valid_q;
	logic [ADDR_W-1:0]          wb_addr_q;
	logic [NODE_W-1:0]          l_q;
	logic [NODE_W-1:0]          r_q;
	logic                       half_q;
	logic                       acc_en_q;
	logic [rsst_pkg::TOT_W-1:0] acc_q;
	logic                       out_valid_q;
	logic [rsst_pkg::TOT_W-1:0] total_q;
	logic [rsst_pkg::STS_W-1:0] out_sts_q;

	// item decode at accept
	logic [N_W-1:0]                n_eff;
	logic [N_W-1:0]                leaf_n;
	logic [N_W-1:0]                lo_n;
	logic [N_W-1:0]                hi_n;
	logic [rsst_pkg::TOT_W:0]      gt_sum;
	logic                          leaf_bad;
	logic [rsst_pkg::STS_W-1:0]    sts_new;
	logic                          q_empty;

	always_comb begin
		n_eff = N_W'(cfg_q);
		if (n_eff == '0) begin
			n_eff = N_W'(1);
		end else if (n_eff > N_W'(MAX_LEAVES)) begin
			n_eff = N_W'(MAX_LEAVES);
		end
		leaf_n   = N_W'(leaf_index);
		lo_n     = (query_low == '0) ? N_W'(1) : N_W'(query_low);
		hi_n     = (N_W'(query_high) > n_eff) ? n_eff : N_W'(query_high);
		q_empty  = lo_n > hi_n;
		gt_sum   = {1'b0, gt_q} + (rsst_pkg::TOT_W + 1)'(add_amount);
		leaf_bad = (leaf_n == '0) || (leaf_n > n_eff);
		sts_new  = rsst_pkg::STS_OK;
		if (cmd == rsst_pkg::CMD_ADD) begin
			if (leaf_bad) begin
				sts_new = rsst_pkg::STS_RANGE;
			end else if (gt_sum[rsst_pkg::TOT_W]) begin
				sts_new = rsst_pkg::STS_OVERFLOW;
			end
		end
	end

	// query walk: read the odd left edge, then the node left of an odd right edge
	logic              q_lt;
	logic              q_both;
	logic              rd_l;
	logic              rd_r;
	logic              q_adv;
	logic [NODE_W-1:0] r_m1;
	logic [NODE_W-1:0] l_up;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [rsst_pkg::TOT_W-1:0] wdata;

	always_comb begin
		q_lt   = l_q < r_q;
		q_both = l_q[0] & r_q[0];
		rd_l   = q_lt && l_q[0] && !half_q;
		rd_r   = q_lt && r_q[0] && !(q_both && !half_q);
		q_adv  = q_lt && !(q_both && !half_q);
		r_m1   = r_q - NODE_W'(1);
		l_up   = l_q + NODE_W'(l_q[0]);
		if (ctl.add_step) begin
			raddr = ptr_q;
		end else if (rd_l) begin
			raddr = ADDR_W'(l_q);
		end else begin
			raddr = ADDR_W'(r_m1);
		end
		if (ctl.clr_step) begin
			we    = 1'b1;
			waddr = ptr_q;
			wdata = '0;
		end else begin
			we    = wb_valid_q;
			waddr = wb_addr_q;
			wdata = rd_data_q + rsst_pkg::TOT_W'(amt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= rsst_pkg::LEAVES_RESET;
			gt_q        <= '0;
			ptr_q       <= '0;
			wb_valid_q  <= 1'b0;
			l_q         <= '0;
			r_q         <= '0;
			half_q      <= 1'b0;
			acc_en_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			wb_valid_q <= ctl.add_step && (ptr_q != '0);
			acc_en_q   <= ctl.qry_step && (rd_l || rd_r);

			if (ctl.clr_start) begin
				ptr_q <= '0;
			end else if (ctl.clr_step) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end else if (ctl.load) begin
				ptr_q <= ADDR_W'(MAX_LEAVES) + ADDR_W'(leaf_n) - ADDR_W'(1);
			end else if (ctl.add_step && (ptr_q != '0)) begin
				ptr_q <= ptr_q >> 1;
			end

			if (ctl.clr_start) begin
				gt_q <= '0;
			end else if (ctl.load && (cmd == rsst_pkg::CMD_ADD) &&
					(sts_new == rsst_pkg::STS_OK)) begin
				gt_q <= gt_sum[rsst_pkg::TOT_W-1:0];
			end

			if (ctl.load) begin
				half_q <= 1'b0;
				if (q_empty) begin
					l_q <= '0;
					r_q <= '0;
				end else begin
					l_q <= NODE_W'(MAX_LEAVES) + NODE_W'(lo_n) - NODE_W'(1);
					r_q <= NODE_W'(MAX_LEAVES) + NODE_W'(hi_n);
				end
			end else if (ctl.qry_step) begin
				if (q_adv) begin
					l_q    <= l_up >> 1;
					r_q    <= r_q >> 1;
					half_q <= 1'b0;
				end else if (q_lt) begin
					half_q <= 1'b1;
				end
			end

			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_q <= ptr_q;
		if (ctl.load) begin
			cmd_q <= cmd;
			amt_q <= add_amount;
			sts_q <= sts_new;
			acc_q <= '0;
		end else if (acc_en_q) begin
			acc_q <= acc_q + rd_data_q;
		end
		if (ctl.finish) begin
			total_q   <= (cmd_q == rsst_pkg::CMD_QUERY) ? acc_q : '0;
			out_sts_q <= sts_q;
		end
	end

	always_comb begin
		sts.add_go   = (cmd_q == rsst_pkg::CMD_ADD) && (sts_q == rsst_pkg::STS_OK);
		sts.is_query = cmd_q == rsst_pkg::CMD_QUERY;
		sts.is_clear = cmd_q == rsst_pkg::CMD_CLEAR;
		sts.add_done = (ptr_q == '0) && !wb_valid_q;
		sts.qry_done = !q_lt && !acc_en_q;
		sts.clr_last = ptr_q == ADDR_W'(SLOTS - 1);
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign range_total = total_q;
	assign status      = out_sts_q;

endmodule

### hdl/rsst_ctrl.sv
module rsst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cfg_we,
	input  rsst_pkg::sts_t sts,
	output rsst_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DECIDE,
		S_ADD,
		S_QRY,
		S_DONE
	} state_t;

	state_t state_q;
	logic   clr_item_q;

	always_comb begin
		ctl = '0;
		case (state_q)
			S_CLR: begin
				ctl.clr_start = cfg_we;
				ctl.clr_step  = !cfg_we;
			end
			S_IDLE: begin
				ctl.clr_start = cfg_we;
				ctl.load      = !cfg_we && in_valid;
			end
			S_DECIDE: begin
				ctl.clr_start = sts.is_clear;
			end
			S_ADD: begin
				ctl.add_step = 1'b1;
			end
			S_QRY: begin
				ctl.qry_step = 1'b1;
			end
			S_DONE: begin
				ctl.finish = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// a register write takes the idle cycle, so no word is taken with it
	assign in_stall = (state_q != S_IDLE) || cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_item_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (!cfg_we && sts.clr_last) begin
						state_q    <= clr_item_q ? S_DONE : S_IDLE;
						clr_item_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (cfg_we) begin
						state_q <= S_CLR;
					end else if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (sts.add_go) begin
						state_q <= S_ADD;
					end else if (sts.is_query) begin
						state_q <= S_QRY;
					end else if (sts.is_clear) begin
						state_q    <= S_CLR;
						clr_item_q <= 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADD: begin
					if (sts.add_done) begin
						state_q <= S_DONE;
					end
				end
				S_QRY: begin
					if (sts.qry_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/range_sum_segment_tree.sv
// point-add / range-sum segment tree over leaves 1..leaves_in_use, node counts held in one
// single-port-style memory of 2*MAX_LEAVES 32-bit words (one write, one registered read per
// cycle); one word in, one word out, one item at a time. an add walks leaf to root, one node
// a cycle, reading the parent while writing the child back; a rejected add goes straight to
// its result word. a query climbs both range edges a level at a time, reading the left edge
// node and then the right edge node when both edges need one. clear, a write of leaves_in_use
// while idle or clearing, and reset all start a clearing pass that zeroes every memory word,
// one per cycle while no register write restarts it; no input word is taken during the pass,
// and a clear command returns its result word after it. rejected adds report status 1 (total
// would pass 32 bits) or 2 (leaf outside 1..leaves_in_use); range_total is zero for everything
// but a query
module range_sum_segment_tree #(
	parameter int MAX_LEAVES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsst_pkg::IDX_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rsst_pkg::CMD_W-1:0]  cmd,
	input  logic [rsst_pkg::IDX_W-1:0]  leaf_index,
	input  logic [rsst_pkg::AMT_W-1:0]  add_amount,
	input  logic [rsst_pkg::IDX_W-1:0]  query_low,
	input  logic [rsst_pkg::IDX_W-1:0]  query_high,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rsst_pkg::TOT_W-1:0]  range_total,
	output logic [rsst_pkg::STS_W-1:0]  status
);

	// sequencing commands and datapath status
	rsst_pkg::ctl_t ctl;
	rsst_pkg::sts_t dp_sts;

	// state machine: accept, decide, walk the tree or sweep, hand the word to the output register
	rsst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cfg_we   (cfg_we),
		.sts      (dp_sts),
		.ctl      (ctl)
	);

	// node memory, edge pointers, running sum, grand total and output register
	rsst_datapath #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (dp_sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.leaf_index  (leaf_index),
		.add_amount  (add_amount),
		.query_low   (query_low),
		.query_high  (query_high),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.range_total (range_total),
		.status      (status)
	);

`ifndef SYNTH
	// an accepted word closes the input side right after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// the controller issues at most one datapath command per cycle
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.clr_start, ctl.clr_step, ctl.add_step, ctl.qry_step,
			ctl.finish}))
		else $error("conflicting datapath commands");

	// a result is only loaded when the output register is free
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !out_valid || !out_stall)
		else $error("result overwrote a pending output word");

	// a rejected add never carries a total
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != rsst_pkg::STS_OK) |-> range_total == '0)
		else $error("nonzero total with error status");
`endif

endmodule
